// ===== design/isodda_pkg.sv =====
// constants, register codes and shared types for the isometric dda line rasterizer
package isodda_pkg;

	localparam int WIN_ROWS        = 1024;
	localparam int WIN_COLS        = 2048;
	localparam int LINE_BYTES      = 8192;
	localparam int BYTES_PER_PIXEL = 4;
	localparam int MAX_STEPS       = 64;

	localparam int IN_W       = 16;
	localparam int COLOR_W    = 32;
	localparam int ADDR_W     = 23;
	localparam int ZSC_W      = 8;
	localparam int TRIG_W     = 16;
	localparam int ZOOM_W     = 16;
	localparam int OFF_W      = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// datapath widths
	localparam int ZZ_W    = 24;
	localparam int PXW     = 40;
	localparam int MA_W    = 25;
	localparam int MB_W    = 18;
	localparam int MP_W    = MA_W + MB_W;
	localparam int FULL_W  = 60;
	localparam int LO_W    = 20;
	localparam int CW      = 50;
	localparam int QB      = 17;
	localparam int SW      = QB + 1;
	localparam int CNTW    = CW - 1 - 16;
	localparam int DSH_W   = CNTW + QB - 1;
	localparam int IT_W    = $clog2(QB + 1);
	localparam int NW      = $clog2(MAX_STEPS + 1);
	localparam int ROW_W   = $clog2(WIN_ROWS);
	localparam int COL_W   = $clog2(WIN_COLS);

	localparam logic signed [CW-1:0] ROW_LIM = CW'(WIN_ROWS) <<< 16;
	localparam logic signed [CW-1:0] COL_LIM = CW'(WIN_COLS) <<< 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PROJECTION_ON = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_Z_SCALE       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COS_THETA     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SIN_THETA     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ZOOM          = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_COL_OFFSET    = 3'd6;

	typedef struct packed {
		logic            start;
		logic            neg;
		logic [CW-2:0]   num;
		logic [CNTW-1:0] den;
	} div_req_t;

endpackage

// ===== design/isodda_seg_if.sv =====
// segment input channel, pixel output channel and configuration write channel
interface isodda_seg_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [isodda_pkg::IN_W-1:0]       a_x;
	logic signed [isodda_pkg::IN_W-1:0]       a_y;
	logic signed [isodda_pkg::IN_W-1:0]       a_z;
	logic        [isodda_pkg::COLOR_W-1:0]    a_color;
	logic signed [isodda_pkg::IN_W-1:0]       b_x;
	logic signed [isodda_pkg::IN_W-1:0]       b_y;
	logic signed [isodda_pkg::IN_W-1:0]       b_z;
	logic        [isodda_pkg::COLOR_W-1:0]    b_color;
	modport source(output valid, a_x, a_y, a_z, a_color, b_x, b_y, b_z, b_color,
		input ready);
	modport sink(input valid, a_x, a_y, a_z, a_color, b_x, b_y, b_z, b_color,
		output ready);
endinterface

interface isodda_pix_if;
	logic                                  valid;
	logic                                  ready;
	logic [isodda_pkg::ADDR_W-1:0]         pixel_address;
	logic [isodda_pkg::COLOR_W-1:0]        pixel_color;
	logic                                  visible;
	logic                                  last;
	logic                                  length_clipped;
	modport source(output valid, pixel_address, pixel_color, visible, last, length_clipped,
		input ready);
	modport sink(input valid, pixel_address, pixel_color, visible, last, length_clipped,
		output ready);
endinterface

interface isodda_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [isodda_pkg::CFG_IDX_W-1:0]      index;
	logic [isodda_pkg::CFG_DATA_W-1:0]     data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== design/isodda_mul.sv =====
// shared signed multiplier with registered product
module isodda_mul (
	input  logic                                 clk,
	input  logic signed [isodda_pkg::MA_W-1:0]   a,
	input  logic signed [isodda_pkg::MB_W-1:0]   b,
	output logic signed [isodda_pkg::MP_W-1:0]   p_q
);

	always_ff @(posedge clk) begin
		p_q <= isodda_pkg::MP_W'(a * b);
	end

endmodule

// ===== design/isodda_div.sv =====
// radix-2 restoring divider for the dda step, quotient bounded to QB bits
module isodda_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  isodda_pkg::div_req_t               req,
	output logic                               done_q,
	output logic signed [isodda_pkg::SW-1:0]   quot
);

	logic [isodda_pkg::DSH_W-1:0] rem_q;
	logic [isodda_pkg::DSH_W-1:0] dsh_q;
	logic [isodda_pkg::QB-1:0]    q_q;
	logic [isodda_pkg::IT_W-1:0]  it_q;
	logic                         neg_q;
	logic                         busy_q;
	logic                         fits;

	assign fits = rem_q >= dsh_q;
	assign quot = neg_q ? -isodda_pkg::SW'(q_q) : isodda_pkg::SW'(q_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q  <= isodda_pkg::DSH_W'(req.num);
				dsh_q  <= isodda_pkg::DSH_W'(req.den) << (isodda_pkg::QB - 1);
				q_q    <= '0;
				neg_q  <= req.neg;
				it_q   <= isodda_pkg::IT_W'(isodda_pkg::QB);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (fits) begin
					rem_q <= rem_q - dsh_q;
				end
				q_q   <= {q_q[isodda_pkg::QB-2:0], fits};
				dsh_q <= dsh_q >> 1;
				it_q  <= it_q - 1'b1;
				if (it_q == isodda_pkg::IT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== design/iso_projected_dda_line_raster.sv =====
// top level: sequencer around the shared multiplier and divider, dda walk and pixel output
//
//  channel | modport | carries
//  seg     | sink    | two endpoints a_*, b_* with colors, one segment per item
//  pix     | source  | pixel_address, pixel_color, visible, last, length_clipped
//  cfg     | sink    | index, data; always ready
//
// a segment passes each endpoint through projection and zoom on the shared multiplier
// (zoom only with projection off), then the step count, two 17-bit restoring
// divisions, then at most 64 pixels, one per cycle while pix does not stall, and
// returns to idle to take the next item.
// seg.ready is high only while the sequencer is idle; a stall on pix holds the walk.
// reset returns the configuration registers to their defaults and empties the output register.
module iso_projected_dda_line_raster (
	input  logic           clk,
	input  logic           arst_n,
	isodda_seg_if.sink     seg,
	isodda_pix_if.source   pix,
	isodda_cfg_if.sink     cfg
);

	typedef enum logic [3:0] {
		S_IDLE, S_ZZ, S_PY, S_PX, S_PXF, S_NOPROJ, S_ZR_LO, S_ZR_HI,
		S_ZC_LO, S_ZC_HI, S_ZC_END, S_CNT, S_DIVR, S_DIVC, S_EMIT
	} state_t;

	state_t state_q;

	// configuration
	logic                                      proj_q;
	logic signed [isodda_pkg::ZSC_W-1:0]       zsc_q;
	logic signed [isodda_pkg::TRIG_W-1:0]      cos_q;
	logic signed [isodda_pkg::TRIG_W-1:0]      sin_q;
	logic        [isodda_pkg::ZOOM_W-1:0]      zoom_q;
	logic signed [isodda_pkg::OFF_W-1:0]       roff_q;
	logic signed [isodda_pkg::OFF_W-1:0]       coff_q;

	// segment
	logic signed [isodda_pkg::IN_W-1:0]        ax_q, ay_q, az_q, bx_q, by_q, bz_q;
	logic        [isodda_pkg::COLOR_W-1:0]     acol_q, bcol_q;
	logic                                      ep_q;
	logic                                      a_zero_q;
	logic signed [isodda_pkg::ZZ_W-1:0]        zz_q;
	logic signed [isodda_pkg::PXW-1:0]         px_q, py_q;
	logic signed [isodda_pkg::MP_W-1:0]        acc_q;
	logic signed [isodda_pkg::CW-1:0]          ar_q, ac_q, br_q, bc_q;
	logic signed [isodda_pkg::CW-1:0]          dc_q;
	logic        [isodda_pkg::CNTW-1:0]        cnt_q;
	logic        [isodda_pkg::NW-1:0]          n_q, k_q;
	logic                                      clip_q;
	logic signed [isodda_pkg::SW-1:0]          sr_q, sc_q;
	logic signed [isodda_pkg::CW-1:0]          r_q, c_q;

	// output register
	logic                                      pix_valid_q;
	logic        [isodda_pkg::ADDR_W-1:0]      addr_q;
	logic        [isodda_pkg::COLOR_W-1:0]     color_q;
	logic                                      vis_q, last_q, lclip_q;

	// shared units
	logic signed [isodda_pkg::MA_W-1:0]        mul_a;
	logic signed [isodda_pkg::MB_W-1:0]        mul_b;
	logic signed [isodda_pkg::MP_W-1:0]        mul_p;
	isodda_pkg::div_req_t                      div_req;
	logic                                      div_done;
	logic signed [isodda_pkg::SW-1:0]          div_quot;

	// combinational
	logic signed [isodda_pkg::IN_W-1:0]        cx, cy, cz;
	logic signed [isodda_pkg::IN_W:0]          sum_xy, dif_xy;
	logic signed [isodda_pkg::CW-1:0]          zoomed;
	logic signed [isodda_pkg::CW-1:0]          dr, dc, mag_r, mag_c, mag_dc;
	logic        [isodda_pkg::CNTW-1:0]        ir, ic, cnt;
	logic                                      emit;
	logic signed [isodda_pkg::CW-1:0]          rr, cc;
	logic                                      vis;
	logic        [31:0]                        lin;

	function automatic logic signed [isodda_pkg::CW-1:0] zoom_fix(
		input logic signed [isodda_pkg::MP_W-1:0] hi,
		input logic signed [isodda_pkg::MP_W-1:0] lo);
		logic signed [isodda_pkg::FULL_W-1:0] f;
		f = (isodda_pkg::FULL_W'(hi) <<< isodda_pkg::LO_W) + isodda_pkg::FULL_W'(lo);
		// q.22 to q.16, truncating toward zero
		if (f[isodda_pkg::FULL_W-1]) begin
			f = f + isodda_pkg::FULL_W'(63);
		end
		return isodda_pkg::CW'(f >>> 6);
	endfunction

	isodda_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	isodda_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done_q (div_done),
		.quot   (div_quot)
	);

	assign cx     = ep_q ? bx_q : ax_q;
	assign cy     = ep_q ? by_q : ay_q;
	assign cz     = ep_q ? bz_q : az_q;
	assign sum_xy = (isodda_pkg::IN_W+1)'(cy) + (isodda_pkg::IN_W+1)'(cx);
	assign dif_xy = (isodda_pkg::IN_W+1)'(cy) - (isodda_pkg::IN_W+1)'(cx);
	assign zoomed = zoom_fix(mul_p, acc_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_ZZ: begin
				mul_a = isodda_pkg::MA_W'(cz);
				mul_b = isodda_pkg::MB_W'(zsc_q);
			end
			S_PY: begin
				mul_a = isodda_pkg::MA_W'(dif_xy);
				mul_b = isodda_pkg::MB_W'(cos_q);
			end
			S_PX: begin
				mul_a = isodda_pkg::MA_W'(sum_xy);
				mul_b = isodda_pkg::MB_W'(sin_q);
			end
			S_ZR_LO: begin
				mul_a = isodda_pkg::MA_W'({1'b0, px_q[isodda_pkg::LO_W-1:0]});
				mul_b = isodda_pkg::MB_W'({1'b0, zoom_q});
			end
			S_ZR_HI: begin
				mul_a = isodda_pkg::MA_W'($signed(px_q[isodda_pkg::PXW-1:isodda_pkg::LO_W]));
				mul_b = isodda_pkg::MB_W'({1'b0, zoom_q});
			end
			S_ZC_LO: begin
				mul_a = isodda_pkg::MA_W'({1'b0, py_q[isodda_pkg::LO_W-1:0]});
				mul_b = isodda_pkg::MB_W'({1'b0, zoom_q});
			end
			S_ZC_HI: begin
				mul_a = isodda_pkg::MA_W'($signed(py_q[isodda_pkg::PXW-1:isodda_pkg::LO_W]));
				mul_b = isodda_pkg::MB_W'({1'b0, zoom_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// segment deltas and step count
	assign dr     = br_q - ar_q;
	assign dc     = bc_q - ac_q;
	assign mag_r  = dr[isodda_pkg::CW-1] ? -dr : dr;
	assign mag_c  = dc[isodda_pkg::CW-1] ? -dc : dc;
	assign mag_dc = dc_q[isodda_pkg::CW-1] ? -dc_q : dc_q;
	assign ir     = mag_r[isodda_pkg::CW-2:16];
	assign ic     = mag_c[isodda_pkg::CW-2:16];
	assign cnt    = (ir > ic) ? ir : ic;

	always_comb begin
		div_req = '0;
		case (state_q)
			S_CNT: begin
				div_req.start = cnt != '0;
				div_req.neg   = dr[isodda_pkg::CW-1];
				div_req.num   = mag_r[isodda_pkg::CW-2:0];
				div_req.den   = cnt;
			end
			S_DIVR: begin
				div_req.start = div_done;
				div_req.neg   = dc_q[isodda_pkg::CW-1];
				div_req.num   = mag_dc[isodda_pkg::CW-2:0];
				div_req.den   = cnt_q;
			end
			default: div_req = '0;
		endcase
	end

	// pixel of the current dda position
	assign emit = (state_q == S_EMIT) && (!pix_valid_q || pix.ready);
	assign rr   = r_q + (isodda_pkg::CW'(roff_q) <<< 16);
	assign cc   = c_q + (isodda_pkg::CW'(coff_q) <<< 16);
	assign vis  = (rr > 0) && (rr < isodda_pkg::ROW_LIM) &&
		(cc > 0) && (cc < isodda_pkg::COL_LIM);
	assign lin  = 32'(rr[16 +: isodda_pkg::ROW_W]) * 32'(isodda_pkg::LINE_BYTES) +
		32'(cc[16 +: isodda_pkg::COL_W]) * 32'(isodda_pkg::BYTES_PER_PIXEL);

	assign seg.ready          = state_q == S_IDLE;
	assign cfg.ready          = 1'b1;
	assign pix.valid          = pix_valid_q;
	assign pix.pixel_address  = addr_q;
	assign pix.pixel_color    = color_q;
	assign pix.visible        = vis_q;
	assign pix.last           = last_q;
	assign pix.length_clipped = lclip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proj_q <= 1'b1;
			zsc_q  <= 8'sd1;
			cos_q  <= 16'sd11415;
			sin_q  <= 16'sd11753;
			zoom_q <= 16'd5120;
			roff_q <= '0;
			coff_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				isodda_pkg::CFG_PROJECTION_ON: proj_q <= cfg.data[0];
				isodda_pkg::CFG_Z_SCALE:       zsc_q  <= cfg.data[isodda_pkg::ZSC_W-1:0];
				isodda_pkg::CFG_COS_THETA:     cos_q  <= cfg.data;
				isodda_pkg::CFG_SIN_THETA:     sin_q  <= cfg.data;
				isodda_pkg::CFG_ZOOM:          zoom_q <= cfg.data;
				isodda_pkg::CFG_ROW_OFFSET:    roff_q <= cfg.data[isodda_pkg::OFF_W-1:0];
				isodda_pkg::CFG_COL_OFFSET:    coff_q <= cfg.data[isodda_pkg::OFF_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pix_valid_q <= 1'b0;
			ep_q        <= 1'b0;
			k_q         <= '0;
			n_q         <= '0;
		end else begin
			if (emit) begin
				pix_valid_q <= 1'b1;
			end else if (pix.ready) begin
				pix_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (seg.valid) begin
						ax_q   <= seg.a_x;
						ay_q   <= seg.a_y;
						az_q   <= seg.a_z;
						acol_q <= seg.a_color;
						bx_q   <= seg.b_x;
						by_q   <= seg.b_y;
						bz_q   <= seg.b_z;
						bcol_q <= seg.b_color;
						ep_q   <= 1'b0;
						state_q <= proj_q ? S_ZZ : S_NOPROJ;
					end
				end
				S_ZZ: state_q <= S_PY;
				S_PY: begin
					zz_q    <= isodda_pkg::ZZ_W'(mul_p);
					state_q <= S_PX;
				end
				S_PX: begin
					py_q    <= isodda_pkg::PXW'(mul_p);
					state_q <= S_PXF;
				end
				S_PXF: begin
					px_q    <= isodda_pkg::PXW'(mul_p) - (isodda_pkg::PXW'(zz_q) <<< 14);
					state_q <= S_ZR_LO;
				end
				S_NOPROJ: begin
					zz_q    <= isodda_pkg::ZZ_W'(cz);
					px_q    <= isodda_pkg::PXW'(cx) <<< 14;
					py_q    <= isodda_pkg::PXW'(cy) <<< 14;
					state_q <= S_ZR_LO;
				end
				S_ZR_LO: state_q <= S_ZR_HI;
				S_ZR_HI: begin
					acc_q   <= mul_p;
					state_q <= S_ZC_LO;
				end
				S_ZC_LO: begin
					if (ep_q) begin
						br_q <= zoomed;
					end else begin
						ar_q <= zoomed;
					end
					state_q <= S_ZC_HI;
				end
				S_ZC_HI: begin
					acc_q   <= mul_p;
					state_q <= S_ZC_END;
				end
				S_ZC_END: begin
					if (ep_q) begin
						bc_q    <= zoomed;
						state_q <= S_CNT;
					end else begin
						ac_q     <= zoomed;
						a_zero_q <= zz_q == '0;
						ep_q     <= 1'b1;
						state_q  <= proj_q ? S_ZZ : S_NOPROJ;
					end
				end
				S_CNT: begin
					dc_q   <= dc;
					cnt_q  <= cnt;
					clip_q <= cnt > isodda_pkg::CNTW'(isodda_pkg::MAX_STEPS);
					n_q    <= (cnt > isodda_pkg::CNTW'(isodda_pkg::MAX_STEPS)) ?
						isodda_pkg::NW'(isodda_pkg::MAX_STEPS) : cnt[isodda_pkg::NW-1:0];
					// no whole-pixel delta: segment yields nothing
					state_q <= (cnt == '0) ? S_IDLE : S_DIVR;
				end
				S_DIVR: begin
					if (div_done) begin
						sr_q    <= div_quot;
						state_q <= S_DIVC;
					end
				end
				S_DIVC: begin
					if (div_done) begin
						sc_q    <= div_quot;
						r_q     <= ar_q;
						c_q     <= ac_q;
						k_q     <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit) begin
						addr_q  <= vis ? lin[isodda_pkg::ADDR_W-1:0] : '0;
						color_q <= a_zero_q ? acol_q : bcol_q;
						vis_q   <= vis;
						last_q  <= k_q == n_q - 1'b1;
						lclip_q <= clip_q;
						r_q     <= r_q + isodda_pkg::CW'(sr_q);
						c_q     <= c_q + isodda_pkg::CW'(sc_q);
						k_q     <= k_q + 1'b1;
						if (k_q == n_q - 1'b1) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (k_q < n_q && n_q <= isodda_pkg::NW'(isodda_pkg::MAX_STEPS)))
		else $error("dda step index out of range");
	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIVR || state_q == S_DIVC))
		else $error("divider finished outside a division state");
	a_hidden_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pix.valid && !pix.visible) |-> (pix.pixel_address == '0))
		else $error("off-window pixel carries an address");
`endif

endmodule

// ===== test/testbench.sv =====
// testbench for the isometric dda line rasterizer: predictor, scoreboard and stimulus
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [isodda_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
	localparam longint FRAC_ONE = 65536;
	localparam int DRAIN_CYCLES = 200;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic signed [isodda_pkg::IN_W-1:0] a_x, a_y, a_z, b_x, b_y, b_z;
		logic [isodda_pkg::COLOR_W-1:0]     a_color, b_color;
	} segment_t;

	typedef struct packed {
		logic [isodda_pkg::ADDR_W-1:0]  addr;
		logic [isodda_pkg::COLOR_W-1:0] color;
		logic                           visible, last, clipped;
	} pixel_t;

	class raster_scoreboard;
		bit     proj_on;
		longint z_mul, cos_q, sin_q, zoom_q, row_off, col_off;
		pixel_t pixel_q[$];
		int     mismatches;

		function new();
			proj_on = 1; z_mul = 1; cos_q = 11415; sin_q = 11753;
			zoom_q = 5120; row_off = 0; col_off = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [isodda_pkg::CFG_IDX_W-1:0] idx,
				logic [isodda_pkg::CFG_DATA_W-1:0] d);
			case (idx)
				isodda_pkg::CFG_PROJECTION_ON: proj_on = d[0];
				isodda_pkg::CFG_Z_SCALE:
					z_mul = longint'($signed(d[isodda_pkg::ZSC_W-1:0]));
				isodda_pkg::CFG_COS_THETA:
					cos_q = longint'($signed(d[isodda_pkg::TRIG_W-1:0]));
				isodda_pkg::CFG_SIN_THETA:
					sin_q = longint'($signed(d[isodda_pkg::TRIG_W-1:0]));
				isodda_pkg::CFG_ZOOM:
					zoom_q = longint'(d[isodda_pkg::ZOOM_W-1:0]);
				isodda_pkg::CFG_ROW_OFFSET:
					row_off = longint'($signed(d[isodda_pkg::OFF_W-1:0]));
				isodda_pkg::CFG_COL_OFFSET:
					col_off = longint'($signed(d[isodda_pkg::OFF_W-1:0]));
				default: ;
			endcase
		endfunction

		// projected and zoomed endpoint in q.16
		function void project(longint x, longint y, longint z,
				output longint rq, output longint cq, output longint zh);
			longint px, py;
			if (proj_on) begin
				zh = z * z_mul;
				py = (y - x) * cos_q;
				px = (y + x) * sin_q - zh * 16384;
			end else begin
				zh = z;
				py = y * 16384;
				px = x * 16384;
			end
			rq = (px * zoom_q) / 64;
			cq = (py * zoom_q) / 64;
		endfunction

		function void note_segment(segment_t s);
			longint ar, ac, az, br, bc, bz, dr, dc, ir, ic, cnt, sr, sc, r, c, rr, cc;
			longint row, col;
			int n;
			bit clip;
			pixel_t p;
			project(s.a_x, s.a_y, s.a_z, ar, ac, az);
			project(s.b_x, s.b_y, s.b_z, br, bc, bz);
			dr = br - ar;
			dc = bc - ac;
			ir = (dr < 0 ? -dr : dr) / FRAC_ONE;
			ic = (dc < 0 ? -dc : dc) / FRAC_ONE;
			cnt = ir > ic ? ir : ic;
			if (cnt == 0)
				return;
			sr = dr / cnt;
			sc = dc / cnt;
			clip = cnt > isodda_pkg::MAX_STEPS;
			n = clip ? isodda_pkg::MAX_STEPS : int'(cnt);
			p.color = (az == 0) ? s.a_color : s.b_color;
			p.clipped = clip;
			r = ar;
			c = ac;
			for (int k = 0; k < n; k++) begin
				rr = r + row_off * FRAC_ONE;
				cc = c + col_off * FRAC_ONE;
				p.visible = rr > 0 && rr < longint'(isodda_pkg::WIN_ROWS) * FRAC_ONE &&
					cc > 0 && cc < longint'(isodda_pkg::WIN_COLS) * FRAC_ONE;
				p.addr = '0;
				if (p.visible) begin
					row = rr / FRAC_ONE;
					col = cc / FRAC_ONE;
					p.addr = isodda_pkg::ADDR_W'(row * isodda_pkg::LINE_BYTES +
						col * isodda_pkg::BYTES_PER_PIXEL);
				end
				p.last = (k == n - 1);
				pixel_q.push_back(p);
				r += sr;
				c += sc;
			end
		endfunction

		function void check_pixel(pixel_t got);
			pixel_t want;
			if (pixel_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected pixel addr=%h color=%h vis=%b last=%b clip=%b",
						got.addr, got.color, got.visible, got.last, got.clipped);
				return;
			end
			want = pixel_q.pop_front();
			if (got != want) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"pixel mismatch: expected addr=%h color=%h vis=%b last=%b ",
						"clip=%b, got addr=%h color=%h vis=%b last=%b clip=%b"},
						want.addr, want.color, want.visible, want.last, want.clipped,
						got.addr, got.color, got.visible, got.last, got.clipped);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	int   sender_idle_pct = 0;
	int   receiver_stall_pct = 0;
	int   hold_request = 0;
	int   hold_left = 0;
	int   quiet_cycles = 0;
	raster_scoreboard sb = new();

	isodda_seg_if seg_ch();
	isodda_pix_if pix_ch();
	isodda_cfg_if cfg_ch();

	iso_projected_dda_line_raster uut (
		.clk(clk), .arst_n(arst_n), .seg(seg_ch), .pix(pix_ch), .cfg(cfg_ch)
	);

	always #5 clk = ~clk;

	// pixel sink with random stalls and a long hold on request
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			pix_ch.ready <= 1'b0;
		end else begin
			pix_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// result monitor and watchdog
	always @(posedge clk) begin
		pixel_t got;
		if (pix_ch.valid && pix_ch.ready) begin
			got.addr = pix_ch.pixel_address;
			got.color = pix_ch.pixel_color;
			got.visible = pix_ch.visible;
			got.last = pix_ch.last;
			got.clipped = pix_ch.length_clipped;
			sb.check_pixel(got);
		end
		if ((pix_ch.valid && pix_ch.ready) || (seg_ch.valid && seg_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready) || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("iso_projected_dda_line_raster verification failed");
			$finish;
		end
	end

	task automatic write_reg(logic [isodda_pkg::CFG_IDX_W-1:0] idx, int value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= isodda_pkg::CFG_DATA_W'(value);
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		sb.write_reg(idx, isodda_pkg::CFG_DATA_W'(value));
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(int proj, int zs, int cs, int sn, int zm, int ro, int co);
		write_reg(isodda_pkg::CFG_PROJECTION_ON, proj);
		write_reg(isodda_pkg::CFG_Z_SCALE, zs);
		write_reg(isodda_pkg::CFG_COS_THETA, cs);
		write_reg(isodda_pkg::CFG_SIN_THETA, sn);
		write_reg(isodda_pkg::CFG_ZOOM, zm);
		write_reg(isodda_pkg::CFG_ROW_OFFSET, ro);
		write_reg(isodda_pkg::CFG_COL_OFFSET, co);
	endtask

	task automatic send_segment(segment_t s);
		while ($urandom_range(99) < sender_idle_pct) begin
			seg_ch.valid <= 1'b0;
			@(posedge clk);
		end
		seg_ch.valid <= 1'b1;
		seg_ch.a_x <= s.a_x; seg_ch.a_y <= s.a_y; seg_ch.a_z <= s.a_z;
		seg_ch.a_color <= s.a_color;
		seg_ch.b_x <= s.b_x; seg_ch.b_y <= s.b_y; seg_ch.b_z <= s.b_z;
		seg_ch.b_color <= s.b_color;
		@(posedge clk);
		while (!seg_ch.ready)
			@(posedge clk);
		sb.note_segment(s);
	endtask

	// wait until every expected pixel is out, plus time for a segment with none
	task automatic drain();
		seg_ch.valid <= 1'b0;
		while (sb.pixel_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic segment_t mk(int ax, int ay, int az, int bx, int by, int bz,
			logic [isodda_pkg::COLOR_W-1:0] ca, logic [isodda_pkg::COLOR_W-1:0] cb);
		segment_t s;
		s.a_x = ax; s.a_y = ay; s.a_z = az;
		s.b_x = bx; s.b_y = by; s.b_z = bz;
		s.a_color = ca; s.b_color = cb;
		return s;
	endfunction

	function automatic int coord(int span);
		if ($urandom_range(99) < 8)
			return $signed(16'($urandom()));
		return $urandom_range(2 * span) - span;
	endfunction

	// mostly short edges near the grid, now and then full-range points
	function automatic segment_t rand_segment(int span);
		segment_t s;
		int ax, ay;
		ax = coord(span);
		ay = coord(span);
		s.a_x = ax; s.a_y = ay;
		s.a_z = ($urandom_range(3) == 0) ? 0 : coord(span / 2);
		s.b_x = ($urandom_range(3) == 0) ? ax + $urandom_range(2) - 1 : coord(span);
		s.b_y = ($urandom_range(3) == 0) ? ay + $urandom_range(2) - 1 : coord(span);
		s.b_z = coord(span / 2);
		s.a_color = $urandom();
		s.b_color = $urandom();
		return s;
	endfunction

	task automatic random_run(int count, int span);
		for (int i = 0; i < count; i++) begin
			send_segment(rand_segment(span));
			// sometimes let the block run dry before the next item
			if ($urandom_range(49) == 0 && sb.pixel_q.size() != 0) begin
				seg_ch.valid <= 1'b0;
				while (sb.pixel_q.size() != 0)
					@(posedge clk);
			end
		end
	endtask

	initial begin
		seg_ch.valid <= 1'b0;
		seg_ch.a_x <= '0; seg_ch.a_y <= '0; seg_ch.a_z <= '0; seg_ch.a_color <= '0;
		seg_ch.b_x <= '0; seg_ch.b_y <= '0; seg_ch.b_z <= '0; seg_ch.b_color <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults, no idling, directed edges
		sender_idle_pct = 0; receiver_stall_pct = 0;
		send_segment(mk(0, 0, 0, 0, 0, 0, 32'h1111_1111, 32'h2222_2222));
		send_segment(mk(0, 0, 0, 1, 0, 0, 32'h0000_0000, 32'hFFFF_FFFF));
		send_segment(mk(0, 0, 3, 1, 0, 0, 32'hFFFF_FFFF, 32'h0000_0000));
		send_segment(mk(32767, 32767, 32767, -32768, -32768, -32768,
			32'hA5A5_A5A5, 32'h5A5A_5A5A));
		send_segment(mk(-32768, -32768, -32768, 32767, 32767, 32767,
			32'h1234_5678, 32'h8765_4321));
		send_segment(mk(10, 10, 0, 12, 14, 0, 32'hCAFE_0001, 32'hCAFE_0002));
		send_segment(mk(-20, -5, 0, -18, -8, 0, 32'h0BAD_0001, 32'h0BAD_0002));
		send_segment(mk(5, 5, 0, 5, 5, 4, 32'h00FF_00FF, 32'hFF00_FF00));
		send_segment(mk(30, 2, -7, 31, 2, 9, 32'h7777_7777, 32'h8888_8888));
		drain();

		// projection off, unit zoom, window edges and a saturated walk
		set_regs(0, 5, 11415, 11753, 256, 0, 0);
		write_reg(CFG_SPARE, 16'hFFFF);
		send_segment(mk(0, 5, 1, 3, 5, 1, 32'h1, 32'h2));
		send_segment(mk(1, 1, 0, 1, 70, 0, 32'h3, 32'h4));
		send_segment(mk(1023, 2047, 0, 1020, 2040, 0, 32'h5, 32'h6));
		send_segment(mk(1020, 2040, 0, 1030, 2050, 0, 32'h7, 32'h8));
		send_segment(mk(4, 4, 0, 4, 4, 9, 32'h9, 32'hA));
		drain();
		set_regs(0, 5, 11415, 11753, 256, 100, 200);
		random_run(70, 40);
		drain();

		// extreme coefficients, sender mostly idle
		sender_idle_pct = 85;
		set_regs(1, -128, -16384, 16384, 65535, 4095, -4096);
		random_run(40, 20);
		drain();
		set_regs(1, 127, 16384, -16384, 65535, -4096, 4095);
		random_run(20, 20);
		drain();

		// zero zoom gives no pixels at all
		sender_idle_pct = 0;
		set_regs(1, 3, 11415, 11753, 0, 10, 10);
		random_run(10, 30);
		drain();

		// receiver mostly stalled, with one long hold so the input backs up
		receiver_stall_pct = 85;
		set_regs(1, 1, 11415, 11753, 5120, 400, 1000);
		hold_request = 400;
		random_run(90, 25);
		drain();

		// both sides idling, random settings
		sender_idle_pct = 34; receiver_stall_pct = 34;
		for (int ph = 0; ph < 3; ph++) begin
			set_regs($urandom_range(1), $urandom_range(255), $urandom_range(32768) - 16384,
				$urandom_range(32768) - 16384, $urandom_range(1023),
				$urandom_range(1000), $urandom_range(2000));
			random_run(50, 30);
			drain();
		end

		while (sb.pixel_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pixel_q.size() == 0)
			$display("iso_projected_dda_line_raster verification clean");
		else
			$display("iso_projected_dda_line_raster verification failed");
		$finish;
	end
endmodule
